>>> hw/rtl/sfdc_pkg.sv
// Shared constants, codes and types of the serial frame deframer.
// No dependencies; imported by all other files of the block.
package sfdc_pkg;

    localparam int PAYLOAD_BYTES = 30;
    localparam int MAX_WORDS     = 15;
    localparam int NWORDS        = ((PAYLOAD_BYTES / 2) > MAX_WORDS) ?
                                   MAX_WORDS : (PAYLOAD_BYTES / 2);
    localparam int STORE_DEPTH   = 2 * NWORDS;
    localparam int STORE_AW      = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
    localparam int ADDR_W        = STORE_AW + 1;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 3);
    localparam int IDX_W         = 4;

    localparam logic [7:0] SYNC_RESET = 8'h88;
    localparam logic [7:0] TYPE_RESET = 8'h55;
    localparam logic [7:0] LEN_VALUE  = 8'(PAYLOAD_BYTES);

    localparam logic REG_SYNC = 1'b0;
    localparam logic REG_TYPE = 1'b1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LO,
        B_HI,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } bank_evt_t;

endpackage

>>> hw/rtl/sfdc_front.sv
// Byte front end: sync hunt, frame count, checksum and frame checks.
// Writes payload into the back end's store; depends on sfdc_pkg.
module sfdc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         sync_value,
    input  logic [7:0]         frame_type,
    output sfdc_pkg::store_wr_t wr,
    output sfdc_pkg::bank_evt_t tok,
    input  sfdc_pkg::bank_evt_t done
);
    import sfdc_pkg::*;

    logic             hunting_reg, hunting_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       type_reg, type_next;
    logic             len_ok_reg, len_ok_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             accept;
    logic [CNT_W-1:0] pidx;

    assign full   = busy_reg[wbank_reg];
    assign accept = push && !full;
    assign pidx   = cnt_reg - CNT_W'(2);

    always_comb
    begin
        hunting_next = hunting_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        len_ok_next  = len_ok_reg;
        wbank_next   = wbank_reg;
        busy_next    = busy_reg;
        wr.en        = 1'b0;
        wr.addr      = {wbank_reg, pidx[STORE_AW-1:0]};
        wr.data      = rx_byte;
        tok.en       = 1'b0;
        tok.bank     = wbank_reg;
        if (done.en)
        begin
            busy_next[done.bank] = 1'b0;
        end
        if (accept)
        begin
            if (hunting_reg)
            begin
                if (rx_byte == sync_value)
                begin
                    hunting_next = 1'b0;
                    cnt_next     = '0;
                    sum_next     = rx_byte;
                end
            end
            else if (cnt_reg < CNT_W'(PAYLOAD_BYTES + 2))
            begin
                sum_next = sum_reg + rx_byte;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(0))
                begin
                    type_next = rx_byte;
                end
                if (cnt_reg == CNT_W'(1))
                begin
                    len_ok_next = (rx_byte == LEN_VALUE);
                end
                if (cnt_reg >= CNT_W'(2) && pidx < CNT_W'(STORE_DEPTH))
                begin
                    wr.en = 1'b1;
                end
            end
            else
            begin
                // checksum byte closes the frame
                hunting_next = 1'b1;
                cnt_next     = '0;
                sum_next     = '0;
                if (type_reg == frame_type && len_ok_reg && sum_reg == rx_byte)
                begin
                    tok.en               = 1'b1;
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = ~wbank_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            len_ok_reg  <= 1'b0;
            wbank_reg   <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            hunting_reg <= hunting_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            len_ok_reg  <= len_ok_next;
            wbank_reg   <= wbank_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
    end

endmodule

>>> hw/rtl/sfdc_tok_fifo.sv
// Two-entry queue of finished-frame bank tokens between front and back.
// Depends on sfdc_pkg.
module sfdc_tok_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  sfdc_pkg::bank_evt_t tok,
    input  logic                pop,
    output logic                valid,
    output logic                bank
);
    import sfdc_pkg::*;

    logic [1:0] mem_reg;
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign valid  = (cnt_reg != 2'd0);
    assign bank   = mem_reg[rptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (tok.en)
        begin
            wptr_next = ~wptr_reg;
        end
        if (do_pop)
        begin
            rptr_next = ~rptr_reg;
        end
        case ({tok.en, do_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok.en)
        begin
            mem_reg[wptr_reg] <= tok.bank;
        end
    end

endmodule

>>> hw/rtl/sfdc_back.sv
// Back end: double-banked payload store, word assembly and result register.
// Depends on sfdc_pkg.
module sfdc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  sfdc_pkg::store_wr_t wr,
    input  logic                tok_valid,
    input  logic                tok_bank,
    output logic                tok_pop,
    output sfdc_pkg::bank_evt_t done,
    output logic                empty,
    input  logic                pop,
    output logic [3:0]          word_index,
    output logic signed [15:0]  word_value,
    output logic                last_word
);
    import sfdc_pkg::*;

    logic [7:0]        store_mem [0:(1 << ADDR_W) - 1];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] raddr;

    back_state_t       state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [7:0]        lo_reg;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_index_reg;
    logic [15:0]       out_value_reg;
    logic              out_last_reg;
    logic              slot_free;
    logic              load;
    logic              is_last;
    logic [STORE_AW-1:0] lo_addr;

    assign slot_free = !out_valid_reg || pop;
    assign is_last   = (k_reg == IDX_W'(NWORDS - 1));
    assign lo_addr   = STORE_AW'({k_reg, 1'b0});

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        k_next     = k_reg;
        tok_pop    = 1'b0;
        load       = 1'b0;
        done.en    = 1'b0;
        done.bank  = bank_reg;
        raddr      = {bank_reg, lo_addr};
        case (state_reg)
            B_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_pop    = 1'b1;
                    bank_next  = tok_bank;
                    k_next     = '0;
                    state_next = B_LO;
                end
            end
            B_LO:
            begin
                state_next = B_HI;
            end
            B_HI:
            begin
                raddr      = {bank_reg, lo_addr | STORE_AW'(1)};
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                // keep the high byte on the read data while the result slot is busy
                raddr = {bank_reg, lo_addr | STORE_AW'(1)};
                if (slot_free)
                begin
                    load = 1'b1;
                    k_next = k_reg + IDX_W'(1);
                    if (is_last)
                    begin
                        done.en    = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_LO;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        k_reg    <= k_next;
        if (state_reg == B_HI)
        begin
            lo_reg <= rdata_reg;
        end
        if (load)
        begin
            out_index_reg <= k_reg;
            out_value_reg <= {rdata_reg, lo_reg};
            out_last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        rdata_reg <= store_mem[raddr];
    end

    assign empty      = !out_valid_reg;
    assign word_index = out_index_reg;
    assign word_value = $signed(out_value_reg);
    assign last_word  = out_last_reg;

endmodule

>>> hw/rtl/sync_frame_deframer_checksum_core.sv
// Serial frame deframer with additive checksum, top level.
// Bytes are taken one per cycle while full is low; full rises only while both payload banks
// hold unsent frames. Words are read out after the checksum byte through one store read
// port, two byte reads per word, and wait in B_EMIT while the result register is occupied.
// Reset (rst_n, async, active low) starts hunting, empties queues and reloads the registers.
// Depends on sfdc_pkg, sfdc_front, sfdc_tok_fifo and sfdc_back.
module sync_frame_deframer_checksum_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         word_index,
    output logic signed [15:0] word_value,
    output logic               last_word
);
    import sfdc_pkg::*;

    logic [7:0] sync_reg;
    logic [7:0] type_reg;
    logic       cfg_wr;
    store_wr_t  wr;
    bank_evt_t  tok;
    bank_evt_t  done;
    logic       tok_valid;
    logic       tok_bank;
    logic       tok_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TYPE) ? {24'd0, type_reg} : {24'd0, sync_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
            type_reg <= TYPE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SYNC)
            begin
                sync_reg <= pwdata[7:0];
            end
            else
            begin
                type_reg <= pwdata[7:0];
            end
        end
    end

    sfdc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .sync_value (sync_reg),
        .frame_type (type_reg),
        .wr         (wr),
        .tok        (tok),
        .done       (done)
    );

    sfdc_tok_fifo u_tok_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok),
        .pop   (tok_pop),
        .valid (tok_valid),
        .bank  (tok_bank)
    );

    sfdc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .tok_valid  (tok_valid),
        .tok_bank   (tok_bank),
        .tok_pop    (tok_pop),
        .done       (done),
        .empty      (empty),
        .pop        (pop),
        .word_index (word_index),
        .word_value (word_value),
        .last_word  (last_word)
    );

endmodule
